FILE: rtl/egcd_pkg.sv
// Package for the extended gcd block: widths, controller-to-datapath command
// and status types. No dependencies.
package egcd_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int COEFF_WIDTH   = OPERAND_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture and order operands, reset recurrences
        logic div_init;  // start a division of r0 by r1
        logic div_step;  // one restoring-division bit
        logic update;    // advance Euclid step and start next division
        logic load_out;  // register final result
    } egcd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic zero_small; // smaller operand is zero
        logic div_last;   // current division bit is the last one
        logic rem_zero;   // remainder of finished division is zero
    } egcd_status_t;

endpackage

FILE: rtl/extended_gcd_bezout_top.sv
// Without a zero smaller operand, one bit-serial division runs per Euclid step.
// Throughput: one transaction at a time; the restoring divider takes one quotient
// bit per cycle and sets the rate. A new transaction is taken while a finished
// result still waits in the output register.
// Reset (rst_n, async, active low) clears control state and the output valid.
module extended_gcd_bezout_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [egcd_pkg::OPERAND_WIDTH-1:0]      operand_a,
    input  logic [egcd_pkg::OPERAND_WIDTH-1:0]      operand_b,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [egcd_pkg::OPERAND_WIDTH-1:0]      gcd_value,
    output logic signed [egcd_pkg::COEFF_WIDTH-1:0] coeff_a,
    output logic signed [egcd_pkg::COEFF_WIDTH-1:0] coeff_b,
    output logic                                    zero_operand
);

    // Command and status between the sequencer and the datapath
    egcd_pkg::egcd_cmd_t    cmd;
    egcd_pkg::egcd_status_t status;

    // Sequencer: idle -> load -> (divide, check, update)* -> finish.
    // The finish state holds until the output register is free.
    egcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: remainders, continuants, bit-serial divider and the
    // result register. Quotient bits feed the continuant accumulators
    // directly, so no quotient storage is needed.
    egcd_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .gcd_value    (gcd_value),
        .coeff_a      (coeff_a),
        .coeff_b      (coeff_b),
        .zero_operand (zero_operand)
    );

endmodule

FILE: rtl/egcd_dpath.sv
// Datapath of the extended gcd block: operand ordering, bit-serial divider
// with on-the-fly continuant accumulation, result mapping. Uses egcd_pkg.
module egcd_dpath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  egcd_pkg::egcd_cmd_t                    cmd,
    output egcd_pkg::egcd_status_t                 status,
    input  logic [egcd_pkg::OPERAND_WIDTH-1:0]     operand_a,
    input  logic [egcd_pkg::OPERAND_WIDTH-1:0]     operand_b,
    output logic [egcd_pkg::OPERAND_WIDTH-1:0]     gcd_value,
    output logic signed [egcd_pkg::COEFF_WIDTH-1:0] coeff_a,
    output logic signed [egcd_pkg::COEFF_WIDTH-1:0] coeff_b,
    output logic                                   zero_operand
);

    localparam int W  = egcd_pkg::OPERAND_WIDTH;
    localparam int CW = egcd_pkg::COEFF_WIDTH;

    logic [W-1:0]   r0_reg, r1_reg, d_reg;
    logic [W-1:0]   k0_reg, k1_reg, l0_reg, l1_reg;
    logic [W-1:0]   kacc_reg, lacc_reg;
    logic [W-1:0]   rem_reg;
    logic [egcd_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic           swapped_reg, zero_reg, n_odd_reg, n_nz_reg;

    logic [W:0]     trial;
    logic           ge;
    logic [W-1:0]   rem_next, kacc_next, lacc_next;
    logic           swapped;
    logic [CW-1:0]  c_big, c_small, k1_ext, l1_ext;

    assign swapped  = operand_a < operand_b;
    assign trial    = {rem_reg, d_reg[W-1]};
    assign ge       = trial >= {1'b0, r1_reg};
    assign rem_next = ge ? W'(trial - {1'b0, r1_reg}) : trial[W-1:0];
    assign kacc_next = {kacc_reg[W-2:0], 1'b0} + (ge ? k1_reg : '0);
    assign lacc_next = {lacc_reg[W-2:0], 1'b0} + (ge ? l1_reg : '0);

    assign status.zero_small = zero_reg;
    assign status.div_last   = cnt_reg == '0;
    assign status.rem_zero   = rem_reg == '0;

    // Datapath registers carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            swapped_reg <= swapped;
            r0_reg      <= swapped ? operand_b : operand_a;
            r1_reg      <= swapped ? operand_a : operand_b;
            zero_reg    <= (swapped ? operand_a : operand_b) == '0;
            k0_reg      <= '0;
            k1_reg      <= W'(1);
            l0_reg      <= '0;
            l1_reg      <= W'(1);
            n_odd_reg   <= 1'b0;
            n_nz_reg    <= 1'b0;
        end
        if (cmd.div_init)
        begin
            d_reg    <= r0_reg;
            rem_reg  <= '0;
            kacc_reg <= '0;
            lacc_reg <= '0;
            cnt_reg  <= egcd_pkg::CNT_WIDTH'(W - 1);
        end
        if (cmd.div_step)
        begin
            d_reg    <= {d_reg[W-2:0], 1'b0};
            rem_reg  <= rem_next;
            kacc_reg <= kacc_next;
            lacc_reg <= lacc_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
        if (cmd.update)
        begin
            n_nz_reg  <= 1'b1;
            n_odd_reg <= ~n_odd_reg;
            // quotient times newest term, plus the older term
            k0_reg    <= k1_reg;
            k1_reg    <= kacc_reg + k0_reg;
            if (n_nz_reg)
            begin
                l0_reg <= l1_reg;
                l1_reg <= lacc_reg + l0_reg;
            end
            r0_reg   <= r1_reg;
            r1_reg   <= rem_reg;
            // start next division of old r1 by remainder
            d_reg    <= r1_reg;
            rem_reg  <= '0;
            kacc_reg <= '0;
            lacc_reg <= '0;
            cnt_reg  <= egcd_pkg::CNT_WIDTH'(W - 1);
        end
    end

    assign k1_ext = {1'b0, k1_reg};
    assign l1_ext = {1'b0, l1_reg};

    always_comb
    begin
        if (zero_reg)
        begin
            c_big   = CW'(1);
            c_small = '0;
        end
        else if (!n_nz_reg)
        begin
            c_big   = '0;
            c_small = CW'(1);
        end
        else if (n_odd_reg)
        begin
            c_big   = l1_ext;
            c_small = CW'(0) - k1_ext;
        end
        else
        begin
            c_big   = CW'(0) - l1_ext;
            c_small = k1_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_operand <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            zero_operand <= zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            gcd_value <= zero_reg ? r0_reg : r1_reg;
            coeff_a   <= swapped_reg ? c_small : c_big;
            coeff_b   <= swapped_reg ? c_big : c_small;
        end
    end

endmodule

FILE: rtl/egcd_ctrl.sv
// Controller of the extended gcd block: sequences load, division bits,
// Euclid updates and result handoff. Uses egcd_pkg.
module egcd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output egcd_pkg::egcd_cmd_t    cmd,
    input  egcd_pkg::egcd_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (status.zero_small)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.rem_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: test/extended_gcd_bezout_top_tb.sv
// Self-checking testbench for extended_gcd_bezout_top: gcd and Bezout coefficients.
// Needs egcd_pkg and the block itself. It drives operand pairs with random gaps and
// output stalls, and checks each result against a built-in Euclid predictor.
`timescale 1ns / 1ps

module extended_gcd_bezout_top_tb;

    localparam int OW = egcd_pkg::OPERAND_WIDTH;
    localparam int CW = egcd_pkg::COEFF_WIDTH;

    // Slowest correct run: 290 pairs, each with the longest Euclid chain plus the longest
    // gap and stall on each side; the limit allows several times that.
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_PAIRS = 266;

    typedef struct {
        logic [OW-1:0] a;
        logic [OW-1:0] b;
    } operand_pair_t;

    typedef struct {
        logic [OW-1:0] gcd;
        logic [CW-1:0] coeff_a;
        logic [CW-1:0] coeff_b;
        logic          zero;
        int unsigned   depth;   // Euclid steps with a nonzero remainder
    } bezout_result_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    logic [OW-1:0] operand_a = '0;
    logic [OW-1:0] operand_b = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [OW-1:0] gcd_value;
    logic signed [CW-1:0] coeff_a;
    logic signed [CW-1:0] coeff_b;
    logic          zero_operand;

    operand_pair_t  pending_operands[$];
    bezout_result_t expected_results[$];

    int unsigned in_gap_left    = 0;
    int unsigned out_stall_left = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned zero_seen      = 0;
    int unsigned deepest_run    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    extended_gcd_bezout_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gcd_value    (gcd_value),
        .coeff_a      (coeff_a),
        .coeff_b      (coeff_b),
        .zero_operand (zero_operand)
    );

    // Predict gcd and signed coefficients: order the operands larger first, run Euclid,
    // and carry two continuants over the quotients (one skipping the first quotient).
    function automatic bezout_result_t compute_bezout(input logic [OW-1:0] a_in,
                                                      input logic [OW-1:0] b_in);
        bezout_result_t res;
        logic           swapped;
        logic [63:0]    larger, smaller, r0, r1, q, r, k0, k1, l0, l1, t;
        logic [CW-1:0]  c_larger, c_smaller;
        int unsigned    steps;
        swapped = a_in < b_in;
        larger  = swapped ? 64'(b_in) : 64'(a_in);
        smaller = swapped ? 64'(a_in) : 64'(b_in);
        steps   = 0;
        res.zero = 1'b0;
        if (smaller == 64'd0) begin
            // Zero smaller operand: gcd is the larger one, which takes coefficient 1
            res.zero  = 1'b1;
            res.gcd   = larger[OW-1:0];
            c_larger  = CW'(1);
            c_smaller = '0;
        end
        else begin
            r0 = larger;
            r1 = smaller;
            k0 = 64'd0;
            k1 = 64'd1;
            l0 = 64'd0;
            l1 = 64'd1;
            q  = r0 / r1;
            r  = r0 % r1;
            while (r != 64'd0) begin
                steps++;
                t  = q * k1 + k0;
                k0 = k1;
                k1 = t;
                if (steps > 1) begin
                    t  = q * l1 + l0;
                    l0 = l1;
                    l1 = t;
                end
                r0 = r1;
                r1 = r;
                q  = r0 / r1;
                r  = r0 % r1;
            end
            res.gcd = r1[OW-1:0];
            if (steps == 0) begin
                // Smaller divides larger (equal operands included)
                c_larger  = '0;
                c_smaller = CW'(1);
            end
            else if (steps[0]) begin
                t         = 64'd0 - k1;
                c_larger  = l1[CW-1:0];
                c_smaller = t[CW-1:0];
            end
            else begin
                t         = 64'd0 - l1;
                c_larger  = t[CW-1:0];
                c_smaller = k1[CW-1:0];
            end
        end
        res.coeff_a = swapped ? c_smaller : c_larger;
        res.coeff_b = swapped ? c_larger : c_smaller;
        res.depth   = steps;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 200);
    endfunction

    task automatic add_pair(input logic [OW-1:0] a_val, input logic [OW-1:0] b_val);
        operand_pair_t p;
        p.a = a_val;
        p.b = b_val;
        pending_operands.push_back(p);
    endtask

    task automatic report_field(input string field, input longint want_v,
                                input longint got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        mismatch_count++;
    endtask

    // Free-running clock, 12 ns period
    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Driver: hold each pair until it is taken, then insert the next gap.
    // Run with no gaps for a stretch in the middle of the stimulus.
    always @(posedge clk)
    begin : drive_operands
        operand_pair_t next_pair;
        bezout_result_t predicted;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            in_gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                // Transaction accepted at this edge: queue its expected result
                predicted = compute_bezout(operand_a, operand_b);
                expected_results.push_back(predicted);
                if (predicted.depth > deepest_run)
                    deepest_run = predicted.depth;
                accepted_count++;
            end
            if (in_gap_left != 0)
            begin
                in_valid    <= 1'b0;
                in_gap_left <= in_gap_left - 1;
            end
            else if (pending_operands.size() != 0)
            begin
                next_pair = pending_operands.pop_front();
                operand_a <= next_pair.a;
                operand_b <= next_pair.b;
                in_valid  <= 1'b1;
                if (accepted_count >= 120 && accepted_count < 170)
                    in_gap_left <= 0;
                else
                    in_gap_left <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction, then
    // decide whether to stall the next cycle. No stalls for a stretch of results.
    always @(posedge clk)
    begin : check_results
        bezout_result_t want;
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            out_stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual gcd %0d coeffs %0d %0d",
                             $time, gcd_value, coeff_a, coeff_b);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (gcd_value !== want.gcd)
                        report_field("gcd_value", longint'(want.gcd), longint'(gcd_value));
                    if (coeff_a !== want.coeff_a)
                        report_field("coeff_a", longint'($signed(want.coeff_a)),
                                     longint'(coeff_a));
                    if (coeff_b !== want.coeff_b)
                        report_field("coeff_b", longint'($signed(want.coeff_b)),
                                     longint'(coeff_b));
                    if (zero_operand !== want.zero)
                        report_field("zero_operand", longint'(want.zero),
                                     longint'(zero_operand));
                    if (want.zero)
                        zero_seen++;
                    checked_count++;
                end
            end
            if (out_stall_left != 0)
            begin
                out_ready      <= 1'b0;
                out_stall_left <= out_stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!(checked_count >= 60 && checked_count < 110) && $urandom_range(0, 2) == 0)
                    out_stall_left <= pick_gap();
            end
        end
    end

    // Timeout guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_results.size());
        $display("Verification failed");
        $finish;
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [63:0]   fa, fb, ft;
        logic [OW-1:0] x, y, g;
        int unsigned   kind, k, m;

        // Directed pairs: zero operands, extremes, divisibility, both step parities,
        // the longest Euclid chain (consecutive Fibonacci numbers) and bit patterns
        add_pair(32'd0, 32'd0);
        add_pair(32'd0, 32'd1);
        add_pair(32'd1, 32'd0);
        add_pair(32'hFFFF_FFFF, 32'd0);
        add_pair(32'd0, 32'hFFFF_FFFF);
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_pair(32'd1, 32'd1);
        add_pair(32'hFFFF_FFFF, 32'd1);
        add_pair(32'd1, 32'hFFFF_FFFF);
        add_pair(32'd12, 32'd4);
        add_pair(32'd4, 32'd12);
        add_pair(32'd7, 32'd3);
        add_pair(32'd3, 32'd7);
        add_pair(32'd13, 32'd8);
        add_pair(32'd240, 32'd46);
        add_pair(32'd46, 32'd240);
        add_pair(32'd2971215073, 32'd1836311903);
        add_pair(32'd1836311903, 32'd2971215073);
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_pair(32'h8000_0000, 32'h7FFF_FFFF);
        add_pair(32'hAAAA_AAAA, 32'h5555_5555);
        add_pair(32'h5555_5555, 32'hAAAA_AAAA);
        add_pair(32'hFFFF_0000, 32'h0000_FFFF);
        add_pair(32'h1234_5678, 32'h8765_4321);

        // Random pairs, mixed across the interesting classes
        repeat (RANDOM_PAIRS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                x = $urandom;
                y = $urandom;
            end
            else if (kind < 45)
            begin
                // Random magnitudes keep most runs short
                x = $urandom >> $urandom_range(0, 31);
                y = $urandom >> $urandom_range(0, 31);
            end
            else if (kind < 60)
            begin
                // Shared random factor, so the gcd is a multiple of it
                g = $urandom_range(1, 65535);
                x = g * $urandom_range(0, 65535);
                y = g * $urandom_range(0, 65535);
            end
            else if (kind < 70)
            begin
                // One operand a multiple of the other
                y = $urandom_range(1, 65535);
                x = y * $urandom_range(1, 65535);
            end
            else if (kind < 80)
            begin
                // Consecutive Fibonacci numbers, sometimes scaled: long chains
                k  = $urandom_range(2, 46);
                fa = 64'd1;
                fb = 64'd0;
                repeat (k)
                begin
                    ft = fa + fb;
                    fb = fa;
                    fa = ft;
                end
                m = $urandom_range(1, 3);
                if (fa * m <= 64'hFFFF_FFFF)
                begin
                    fa = fa * m;
                    fb = fb * m;
                end
                x = fa[OW-1:0];
                y = fb[OW-1:0];
            end
            else if (kind < 88)
            begin
                x = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
                y = '0;
            end
            else if (kind < 94)
            begin
                x = $urandom;
                y = x;
            end
            else
            begin
                x = 32'hFFFF_FFFF - $urandom_range(0, 15);
                y = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 15);
            end
            if ($urandom_range(0, 1) != 0)
                add_pair(y, x);
            else
                add_pair(x, y);
        end

        // Hold reset, then release it once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every pair has been taken and every result has come back
        do
            @(negedge clk);
        while (pending_operands.size() != 0 || in_valid || expected_results.size() != 0);

        // Drain: any stray result in this window is flagged by the monitor
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d operand pairs and checked %0d results in %0d cycles",
                 accepted_count, checked_count, cycle_count);
        $display("Zero-operand results: %0d, longest Euclid chain: %0d steps",
                 zero_seen, deepest_run);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
